/* sv/tst_pkg.sv */
package tst_pkg;

  // Identifier buffer sizing
  localparam int MAX_ID_LEN = 32;
  localparam int IDLEN_W    = 6;
  localparam int IDX_W      = $clog2(MAX_ID_LEN);
  localparam logic [IDLEN_W-1:0] ID_MAX = IDLEN_W'(MAX_ID_LEN);

  // Keyword table sizing
  localparam int NUM_KW = 21;
  localparam int KW_W   = 5;
  localparam logic [IDLEN_W-1:0] KW_SCAN = IDLEN_W'(8);

  localparam logic [34:0] INT_MAX = 35'h0_7FFF_FFFF;
  localparam logic [3:0]  FRAC_MAX = 4'd10;

  // Queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // Token kinds
  localparam logic [5:0] K_ETX      = 6'd0;
  localparam logic [5:0] K_LPAREN   = 6'd1;
  localparam logic [5:0] K_RPAREN   = 6'd2;
  localparam logic [5:0] K_LBRACE   = 6'd3;
  localparam logic [5:0] K_RBRACE   = 6'd4;
  localparam logic [5:0] K_COMMA    = 6'd5;
  localparam logic [5:0] K_DOT      = 6'd6;
  localparam logic [5:0] K_MINUS    = 6'd7;
  localparam logic [5:0] K_PLUS     = 6'd8;
  localparam logic [5:0] K_SEMI     = 6'd9;
  localparam logic [5:0] K_STAR     = 6'd10;
  localparam logic [5:0] K_EXCL     = 6'd11;
  localparam logic [5:0] K_NEQ      = 6'd12;
  localparam logic [5:0] K_ASSIGN   = 6'd13;
  localparam logic [5:0] K_EQEQ     = 6'd14;
  localparam logic [5:0] K_ARROW    = 6'd15;
  localparam logic [5:0] K_LESS     = 6'd16;
  localparam logic [5:0] K_LE       = 6'd17;
  localparam logic [5:0] K_GREATER  = 6'd18;
  localparam logic [5:0] K_GE       = 6'd19;
  localparam logic [5:0] K_SLASH    = 6'd20;
  localparam logic [5:0] K_COMMENT  = 6'd21;
  localparam logic [5:0] K_STRING   = 6'd22;
  localparam logic [5:0] K_IDENT    = 6'd23;
  localparam logic [5:0] K_INT      = 6'd24;
  localparam logic [5:0] K_DECIMAL  = 6'd25;
  localparam logic [5:0] K_KEYWORD0 = 6'd26;
  localparam logic [5:0] K_TEXT     = 6'd47;
  localparam logic [5:0] K_ERROR    = 6'd48;

  // Error codes
  localparam logic [3:0] E_NONE       = 4'd0;
  localparam logic [3:0] E_OPEN_STR   = 4'd1;
  localparam logic [3:0] E_LEAD_ZERO  = 4'd2;
  localparam logic [3:0] E_INT_OVF    = 4'd3;
  localparam logic [3:0] E_DEC_RANGE  = 4'd4;
  localparam logic [3:0] E_NO_FRAC    = 4'd5;
  localparam logic [3:0] E_LONG_ID    = 4'd6;
  localparam logic [3:0] E_OPEN_BLOCK = 4'd7;
  localparam logic [3:0] E_UNKNOWN    = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_OP, PH_SLASH, PH_LINE, PH_BLOCK, PH_BLOCK_STAR,
    PH_STRING, PH_IDENT, PH_ZERO, PH_INT, PH_FRAC
  } phase_e;

  typedef enum logic [1:0] {
    FE_TAKE, FE_RUN, FE_SECOND, FE_REPLAY
  } fe_state_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] num;
    logic [3:0]  frac;
    logic [7:0]  ch;
    logic [3:0]  err;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // Keyword spellings, right-justified, and their lengths
  localparam logic [63:0] KW_WORD [NUM_KW] = '{
    "if", "else", "and", "or", "true", "false", "while", "return", "is", "as",
    "print", "inspect", "struct", "variant", "int", "float", "str", "bool",
    "void", "mut", "default"};
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd4, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd6, 4'd2, 4'd2,
    4'd5, 4'd7, 4'd6, 4'd7, 4'd3, 4'd5, 4'd3, 4'd4, 4'd4, 4'd3, 4'd7};

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
    int   pos;
    logic [7:0] ch;
    ch  = '0;
    pos = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
    if ({1'b0, i} < KW_LEN[k]) ch = KW_WORD[k][pos +: 8];
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic item_t mk_token(input logic [5:0] kind);
    item_t it;
    it      = '0;
    it.kind = kind;
    it.last = 1'b1;
    return it;
  endfunction

  function automatic item_t mk_error(input logic [3:0] code);
    item_t it;
    it      = '0;
    it.kind = K_ERROR;
    it.err  = code;
    it.last = 1'b1;
    return it;
  endfunction

  function automatic item_t mk_text(input logic [7:0] ch);
    item_t it;
    it      = '0;
    it.kind = K_TEXT;
    it.ch   = ch;
    return it;
  endfunction

endpackage

/* sv/tst_front.sv */
module tst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             drop_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             full_i,
  output tst_pkg::push_t   push_o
);

  tst_pkg::fe_state_e state_q, state_d;
  tst_pkg::phase_e    phase_q, phase_d;
  logic [7:0]                  held_q, held_d;
  logic [7:0]                  byte_q;
  logic [30:0]                 acc_q, acc_d;
  logic [3:0]                  frac_q, frac_d;
  logic [tst_pkg::IDLEN_W-1:0] len_q, len_d;
  logic [tst_pkg::IDLEN_W-1:0] idx_q, idx_d;
  logic [tst_pkg::NUM_KW-1:0]  kwm_q, kwm_d;
  logic [7:0]                  id_mem_q [tst_pkg::MAX_ID_LEN];
  logic [7:0]                  run_ch_q;

  logic                        act;
  logic                        pv;
  tst_pkg::item_t              item;
  logic                        replay_req, second_req, run_req;
  logic                        wr_en;
  logic [tst_pkg::IDX_W-1:0]   wr_addr;
  logic [7:0]                  wr_data;
  logic [7:0]                  c;
  logic [3:0]                  d;
  logic [34:0]                 wide;
  logic                        ovf;
  logic                        cmt_ok;
  logic                        hit;
  logic [tst_pkg::KW_W-1:0]    hitk;

  assign in_ready_o = (state_q == tst_pkg::FE_TAKE) && !full_i;
  assign act = (state_q == tst_pkg::FE_TAKE) ? (in_valid_i && !full_i) : !full_i;
  assign c   = (state_q == tst_pkg::FE_TAKE) ? in_byte_i : byte_q;
  assign d   = c[3:0];
  assign cmt_ok = !drop_i;

  // Scale and add one decimal digit
  assign wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {31'b0, d};
  assign ovf  = wide > tst_pkg::INT_MAX;

  // Look up a finished identifier among the keywords, lowest entry first
  always_comb begin
    hit  = 1'b0;
    hitk = '0;
    for (int k = tst_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (kwm_q[k] && ({2'b0, tst_pkg::KW_LEN[k]} == len_q)) begin
        hit  = 1'b1;
        hitk = tst_pkg::KW_W'(k);
      end
    end
  end

  // Classify the byte and form at most one item per cycle
  always_comb begin
    pv         = 1'b0;
    item       = '0;
    replay_req = 1'b0;
    second_req = 1'b0;
    run_req    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = c;
    phase_d    = phase_q;
    held_d     = held_q;
    acc_d      = acc_q;
    frac_d     = frac_q;
    len_d      = len_q;
    kwm_d      = kwm_q;
    case (state_q)
      tst_pkg::FE_RUN: begin
        pv = 1'b1;
        if (idx_q == len_q) item = tst_pkg::mk_token(tst_pkg::K_IDENT);
        else item = tst_pkg::mk_text(run_ch_q);
      end
      tst_pkg::FE_SECOND: begin
        pv   = cmt_ok;
        item = tst_pkg::mk_text(c);
      end
      tst_pkg::FE_TAKE: begin
        case (phase_q)
          tst_pkg::PH_IDLE: ;
          tst_pkg::PH_OP: begin
            replay_req = 1'b1;
            pv         = 1'b1;
            phase_d    = tst_pkg::PH_IDLE;
            if (held_q == "!") begin
              if (c == "=") begin
                item = tst_pkg::mk_token(tst_pkg::K_NEQ);
                replay_req = 1'b0;
              end else item = tst_pkg::mk_token(tst_pkg::K_EXCL);
            end else if (held_q == "=") begin
              if (c == "=") begin
                item = tst_pkg::mk_token(tst_pkg::K_EQEQ);
                replay_req = 1'b0;
              end else if (c == ">") begin
                item = tst_pkg::mk_token(tst_pkg::K_ARROW);
                replay_req = 1'b0;
              end else item = tst_pkg::mk_token(tst_pkg::K_ASSIGN);
            end else if (held_q == "<") begin
              if (c == "=") begin
                item = tst_pkg::mk_token(tst_pkg::K_LE);
                replay_req = 1'b0;
              end else item = tst_pkg::mk_token(tst_pkg::K_LESS);
            end else begin
              if (c == "=") begin
                item = tst_pkg::mk_token(tst_pkg::K_GE);
                replay_req = 1'b0;
              end else item = tst_pkg::mk_token(tst_pkg::K_GREATER);
            end
            held_d = '0;
          end
          tst_pkg::PH_SLASH: begin
            if (c == "/") phase_d = tst_pkg::PH_LINE;
            else if (c == "*") phase_d = tst_pkg::PH_BLOCK;
            else begin
              pv         = 1'b1;
              item       = tst_pkg::mk_token(tst_pkg::K_SLASH);
              replay_req = 1'b1;
            end
          end
          tst_pkg::PH_LINE: begin
            if ((c == 8'h0a) || (c == 8'h00)) begin
              pv         = cmt_ok;
              item       = tst_pkg::mk_token(tst_pkg::K_COMMENT);
              phase_d    = tst_pkg::PH_IDLE;
              replay_req = (c == 8'h00);
            end else begin
              pv   = cmt_ok;
              item = tst_pkg::mk_text(c);
            end
          end
          tst_pkg::PH_BLOCK, tst_pkg::PH_BLOCK_STAR: begin
            if (c == 8'h00) begin
              pv         = 1'b1;
              item       = tst_pkg::mk_error(tst_pkg::E_OPEN_BLOCK);
              phase_d    = tst_pkg::PH_IDLE;
              replay_req = 1'b1;
            end else if (phase_q == tst_pkg::PH_BLOCK_STAR) begin
              if (c == "/") begin
                pv      = cmt_ok;
                item    = tst_pkg::mk_token(tst_pkg::K_COMMENT);
                phase_d = tst_pkg::PH_IDLE;
              end else begin
                // Flush the held star, then the byte itself; a further star is held instead
                pv   = cmt_ok;
                item = tst_pkg::mk_text("*");
                if (c != "*") begin
                  phase_d    = tst_pkg::PH_BLOCK;
                  second_req = 1'b1;
                end
              end
            end else if (c == "*") begin
              phase_d = tst_pkg::PH_BLOCK_STAR;
            end else begin
              pv   = cmt_ok;
              item = tst_pkg::mk_text(c);
            end
          end
          tst_pkg::PH_STRING: begin
            if (c == 8'h22) begin
              pv      = 1'b1;
              item    = tst_pkg::mk_token(tst_pkg::K_STRING);
              phase_d = tst_pkg::PH_IDLE;
            end else if ((c == 8'h0a) || (c == 8'h00)) begin
              pv         = 1'b1;
              item       = tst_pkg::mk_error(tst_pkg::E_OPEN_STR);
              phase_d    = tst_pkg::PH_IDLE;
              replay_req = 1'b1;
            end else begin
              pv   = 1'b1;
              item = tst_pkg::mk_text(c);
            end
          end
          tst_pkg::PH_IDENT: begin
            if (tst_pkg::is_alpha(c) || tst_pkg::is_digit(c) || (c == "_")) begin
              if (len_q < tst_pkg::ID_MAX) begin
                wr_en   = 1'b1;
                wr_addr = len_q[tst_pkg::IDX_W-1:0];
              end
              if (len_q <= tst_pkg::ID_MAX) len_d = len_q + 1'b1;
              if (len_q < tst_pkg::KW_SCAN) begin
                for (int k = 0; k < tst_pkg::NUM_KW; k++)
                  kwm_d[k] = kwm_q[k] && (tst_pkg::kw_char(k, len_q[2:0]) == c);
              end
            end else if (hit) begin
              pv         = 1'b1;
              item       = tst_pkg::mk_token(tst_pkg::K_KEYWORD0 + {1'b0, hitk});
              replay_req = 1'b1;
            end else if (len_q > tst_pkg::ID_MAX) begin
              pv         = 1'b1;
              item       = tst_pkg::mk_error(tst_pkg::E_LONG_ID);
              replay_req = 1'b1;
            end else begin
              run_req = 1'b1;
            end
          end
          tst_pkg::PH_ZERO, tst_pkg::PH_INT: begin
            if ((phase_q == tst_pkg::PH_ZERO) && (c == "0")) begin
              pv         = 1'b1;
              item       = tst_pkg::mk_error(tst_pkg::E_LEAD_ZERO);
              replay_req = 1'b1;
            end else if (tst_pkg::is_digit(c)) begin
              if (ovf) begin
                pv      = 1'b1;
                item    = tst_pkg::mk_error(tst_pkg::E_INT_OVF);
                phase_d = tst_pkg::PH_IDLE;
                acc_d   = '0;
              end else begin
                acc_d   = wide[30:0];
                phase_d = tst_pkg::PH_INT;
              end
            end else if (c == ".") begin
              frac_d  = '0;
              phase_d = tst_pkg::PH_FRAC;
            end else begin
              pv         = 1'b1;
              item       = tst_pkg::mk_token(tst_pkg::K_INT);
              item.num   = acc_q;
              replay_req = 1'b1;
            end
          end
          tst_pkg::PH_FRAC: begin
            if (tst_pkg::is_digit(c)) begin
              if (ovf || (frac_q >= tst_pkg::FRAC_MAX)) begin
                pv      = 1'b1;
                item    = tst_pkg::mk_error(tst_pkg::E_DEC_RANGE);
                phase_d = tst_pkg::PH_IDLE;
                acc_d   = '0;
                frac_d  = '0;
              end else begin
                acc_d  = wide[30:0];
                frac_d = frac_q + 1'b1;
              end
            end else begin
              pv         = 1'b1;
              replay_req = 1'b1;
              if (frac_q == '0) item = tst_pkg::mk_error(tst_pkg::E_NO_FRAC);
              else begin
                item      = tst_pkg::mk_token(tst_pkg::K_DECIMAL);
                item.num  = acc_q;
                item.frac = frac_q;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // Start a new token from this byte
    if ((state_q == tst_pkg::FE_REPLAY) ||
        ((state_q == tst_pkg::FE_TAKE) && (phase_q == tst_pkg::PH_IDLE))) begin
      phase_d = tst_pkg::PH_IDLE;
      held_d  = '0;
      acc_d   = '0;
      frac_d  = '0;
      len_d   = '0;
      pv      = 1'b1;
      case (c)
        8'h00: item = tst_pkg::mk_token(tst_pkg::K_ETX);
        "(":   item = tst_pkg::mk_token(tst_pkg::K_LPAREN);
        ")":   item = tst_pkg::mk_token(tst_pkg::K_RPAREN);
        "{":   item = tst_pkg::mk_token(tst_pkg::K_LBRACE);
        "}":   item = tst_pkg::mk_token(tst_pkg::K_RBRACE);
        ",":   item = tst_pkg::mk_token(tst_pkg::K_COMMA);
        ".":   item = tst_pkg::mk_token(tst_pkg::K_DOT);
        "-":   item = tst_pkg::mk_token(tst_pkg::K_MINUS);
        "+":   item = tst_pkg::mk_token(tst_pkg::K_PLUS);
        ";":   item = tst_pkg::mk_token(tst_pkg::K_SEMI);
        "*":   item = tst_pkg::mk_token(tst_pkg::K_STAR);
        "!", "=", "<", ">": begin
          pv      = 1'b0;
          held_d  = c;
          phase_d = tst_pkg::PH_OP;
        end
        "/": begin
          pv      = 1'b0;
          phase_d = tst_pkg::PH_SLASH;
        end
        8'h22: begin
          pv      = 1'b0;
          phase_d = tst_pkg::PH_STRING;
        end
        default: begin
          if (tst_pkg::is_alpha(c) || (c == "_")) begin
            pv      = 1'b0;
            wr_en   = 1'b1;
            wr_addr = '0;
            len_d   = tst_pkg::IDLEN_W'(1);
            phase_d = tst_pkg::PH_IDENT;
            for (int k = 0; k < tst_pkg::NUM_KW; k++)
              kwm_d[k] = (tst_pkg::kw_char(k, 3'd0) == c);
          end else if (tst_pkg::is_digit(c)) begin
            pv      = 1'b0;
            acc_d   = {27'b0, d};
            phase_d = (c == "0") ? tst_pkg::PH_ZERO : tst_pkg::PH_INT;
          end else if (tst_pkg::is_space(c)) begin
            pv = 1'b0;
          end else begin
            item = tst_pkg::mk_error(tst_pkg::E_UNKNOWN);
          end
        end
      endcase
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      tst_pkg::FE_TAKE: begin
        idx_d = '0;
        if (act) begin
          if (run_req) state_d = tst_pkg::FE_RUN;
          else if (second_req) state_d = tst_pkg::FE_SECOND;
          else if (replay_req) state_d = tst_pkg::FE_REPLAY;
        end
      end
      tst_pkg::FE_RUN: begin
        if (act) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == len_q) state_d = tst_pkg::FE_REPLAY;
        end
      end
      tst_pkg::FE_SECOND: if (act) state_d = tst_pkg::FE_TAKE;
      tst_pkg::FE_REPLAY: if (act) state_d = tst_pkg::FE_TAKE;
      default: state_d = tst_pkg::FE_TAKE;
    endcase
  end

  assign push_o.valid = pv && act;
  assign push_o.item  = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tst_pkg::FE_TAKE;
      phase_q <= tst_pkg::PH_IDLE;
      held_q  <= '0;
      byte_q  <= '0;
      acc_q   <= '0;
      frac_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      kwm_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (act) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        acc_q   <= acc_d;
        frac_q  <= frac_d;
        len_q   <= len_d;
        kwm_q   <= kwm_d;
        if (state_q == tst_pkg::FE_TAKE) byte_q <= in_byte_i;
      end
    end
  end

  // Identifier characters; the next run character is read into a register ahead of its use
  always_ff @(posedge clk_i) begin
    if (act && wr_en) id_mem_q[wr_addr] <= wr_data;
    run_ch_q <= id_mem_q[idx_d[tst_pkg::IDX_W-1:0]];
  end

endmodule

/* sv/tst_back.sv */
module tst_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tst_pkg::push_t  push_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tst_pkg::item_t  out_item_o
);

  tst_pkg::item_t           fifo_q [tst_pkg::FIFO_DEPTH];
  logic [tst_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [tst_pkg::CNT_W-1:0] cnt_q;
  logic                      out_valid_q;
  tst_pkg::item_t            out_q;
  logic                      pop;

  function automatic logic [tst_pkg::CNT_W-1:0] CNT_INC(input logic b);
    return {{(tst_pkg::CNT_W-1){1'b0}}, b};
  endfunction

  assign full_o      = cnt_q == tst_pkg::CNT_W'(tst_pkg::FIFO_DEPTH);
  assign pop         = (cnt_q != '0) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Queue pointers and output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_i.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CNT_INC(push_i.valid) - CNT_INC(pop);
      if (pop) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Queue storage and output payload
  always_ff @(posedge clk_i) begin
    if (push_i.valid) fifo_q[wr_ptr_q] <= push_i.item;
    if (pop) out_q <= fifo_q[rd_ptr_q];
  end

endmodule

/* sv/source_text_tokenizer_unit.sv */
// Source text tokenizer.
// Input channel s_axis: one source byte per item in tdata[7:0]; byte 0 ends the text.
// Output channel m_axis: one result item per transfer. tuser carries the token kind,
// tdata the number value, fraction digits, text byte and error code, tlast is set on
// the item that closes a token or error (text byte items have tlast low).
// Config channel cfg: one write sets drop_comments; write it only while idle.
// A byte that closes one token and starts the next is scanned a second time, as is
// a byte other than a star or slash after a star inside a block comment. A byte that
// closes a plain identifier is held while the identifier's characters are replayed
// from the identifier buffer. The front sequencer pushes at most one item per cycle
// into a four-entry queue, and it stalls while that queue is full.
// A result passes through the queue and then the registered output stage.
// Reset clears the scanner to its idle state, empties the queue and drop_comments.
// A stalled receiver fills the queue, after which s_axis_tready_o drops.
module source_text_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] text_byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [30:0] number_value, [34:31] fraction_digits, [42:35] text_char,
  // [46:43] error_code, [47] zero
  output logic [47:0] m_axis_tdata_o,
  output logic [5:0]  m_axis_tuser_o,  // [5:0] token_kind
  output logic        m_axis_tlast_o,  // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic           drop_q;
  logic           full;
  tst_pkg::push_t push;
  tst_pkg::item_t out_item;

  assign cfg_ready_o = 1'b1;

  // Hold the comment drop setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) drop_q <= 1'b0;
    else if (cfg_valid_i) drop_q <= cfg_data_i;
  end

  tst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .drop_i     (drop_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .full_i     (full),
    .push_o     (push)
  );

  tst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata_o = {1'b0, out_item.err, out_item.ch, out_item.frac, out_item.num};
  assign m_axis_tuser_o = out_item.kind;
  assign m_axis_tlast_o = out_item.last;

  // Text byte items are exactly the open ones
  a_text_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == tst_pkg::K_TEXT) == !m_axis_tlast_o))
    else $error("text item and tlast disagree");

  // Error code only on error items
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((m_axis_tuser_o == tst_pkg::K_ERROR) == (m_axis_tdata_o[46:43] != 4'd0)))
    else $error("error code on wrong kind");

  // Fraction digits only on decimals
  a_frac_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[34:31] != 4'd0)) |->
      (m_axis_tuser_o == tst_pkg::K_DECIMAL))
    else $error("fraction digits on non-decimal");

  // No byte is taken while the queue is full
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !s_axis_tready_o)
    else $error("byte taken with full queue");

endmodule

/* test/tb_source_text_tokenizer_unit.sv */
`timescale 1ns / 100ps

module tb_source_text_tokenizer_unit;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] num;
    logic [3:0]  frac;
    logic [7:0]  ch;
    logic [3:0]  err;
    logic        last;
  } token_rec_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;
  logic [5:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  source_text_tokenizer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Predictor state
  logic            drop_cmt;
  tst_pkg::phase_e phase = tst_pkg::PH_IDLE;
  logic [7:0]      held = '0;
  logic [30:0]     accum = '0;
  logic [3:0]      fcount = '0;
  logic [7:0]      idbuf [tst_pkg::MAX_ID_LEN];
  int              idlen = 0;

  token_rec_t  tokens_due[$];
  logic [7:0]  bytes_pending[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          hold_off = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  bit          in_taken = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  string kw_words[21] = '{"if", "else", "and", "or", "true", "false", "while", "return",
                          "is", "as", "print", "inspect", "struct", "variant", "int",
                          "float", "str", "bool", "void", "mut", "default"};

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void emit(logic [5:0] kind, logic [30:0] num, logic [3:0] frac,
                               logic [7:0] ch, logic [3:0] err, logic last);
    token_rec_t r;
    r.kind = kind; r.num = num; r.frac = frac; r.ch = ch; r.err = err; r.last = last;
    tokens_due.push_back(r);
  endfunction

  function automatic void emit_tok(logic [5:0] kind);
    emit(kind, '0, '0, '0, tst_pkg::E_NONE, 1'b1);
  endfunction

  function automatic void emit_err(logic [3:0] code);
    emit(tst_pkg::K_ERROR, '0, '0, '0, code, 1'b1);
  endfunction

  function automatic void emit_text(logic [7:0] ch);
    if (!drop_cmt ||
        !(phase inside {tst_pkg::PH_LINE, tst_pkg::PH_BLOCK, tst_pkg::PH_BLOCK_STAR}))
      emit(tst_pkg::K_TEXT, '0, '0, ch, tst_pkg::E_NONE, 1'b0);
  endfunction

  function automatic void clear_scan();
    phase = tst_pkg::PH_IDLE; held = '0; accum = '0; fcount = '0; idlen = 0;
  endfunction

  function automatic void close_ident();
    string w;
    bit    hit;
    for (int k = 0; k < 21; k++) begin
      w = kw_words[k];
      hit = (w.len() == idlen);
      for (int i = 0; i < w.len() && hit; i++)
        if (idbuf[i] != w[i]) hit = 0;
      if (hit) begin
        emit_tok(tst_pkg::K_KEYWORD0 + 6'(k));
        return;
      end
    end
    if (idlen > tst_pkg::MAX_ID_LEN) begin
      emit_err(tst_pkg::E_LONG_ID);
      return;
    end
    for (int i = 0; i < idlen; i++)
      emit(tst_pkg::K_TEXT, '0, '0, idbuf[i], tst_pkg::E_NONE, 1'b0);
    emit_tok(tst_pkg::K_IDENT);
  endfunction

  task automatic start_token(logic [7:0] c);
    clear_scan();
    case (c)
      8'd0: emit_tok(tst_pkg::K_ETX);
      "(":  emit_tok(tst_pkg::K_LPAREN);
      ")":  emit_tok(tst_pkg::K_RPAREN);
      "{":  emit_tok(tst_pkg::K_LBRACE);
      "}":  emit_tok(tst_pkg::K_RBRACE);
      ",":  emit_tok(tst_pkg::K_COMMA);
      ".":  emit_tok(tst_pkg::K_DOT);
      "-":  emit_tok(tst_pkg::K_MINUS);
      "+":  emit_tok(tst_pkg::K_PLUS);
      ";":  emit_tok(tst_pkg::K_SEMI);
      "*":  emit_tok(tst_pkg::K_STAR);
      "!", "=", "<", ">": begin
        held = c; phase = tst_pkg::PH_OP;
      end
      "/":  phase = tst_pkg::PH_SLASH;
      "\"": phase = tst_pkg::PH_STRING;
      default: begin
        if (alpha_c(c) || c == "_") begin
          idbuf[0] = c; idlen = 1; phase = tst_pkg::PH_IDENT;
        end else if (digit_c(c)) begin
          accum = 31'(c - "0");
          phase = (c == "0") ? tst_pkg::PH_ZERO : tst_pkg::PH_INT;
        end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          emit_err(tst_pkg::E_UNKNOWN);
        end
      end
    endcase
  endtask

  // Returns 1 when the byte must also start a new token
  function automatic bit continue_token(logic [7:0] c);
    logic [31:0] d;
    logic [31:0] lim;
    d = 32'(c) - 32'("0");
    lim = (32'h7FFF_FFFF - d) / 10;
    case (phase)
      tst_pkg::PH_OP: begin
        if (c == "=" && held != "=") begin
          emit_tok(held == "!" ? tst_pkg::K_NEQ : held == "<" ? tst_pkg::K_LE : tst_pkg::K_GE);
          clear_scan(); return 0;
        end
        if (held == "=" && (c == "=" || c == ">")) begin
          emit_tok(c == "=" ? tst_pkg::K_EQEQ : tst_pkg::K_ARROW);
          clear_scan(); return 0;
        end
        emit_tok(held == "!" ? tst_pkg::K_EXCL : held == "=" ? tst_pkg::K_ASSIGN :
                 held == "<" ? tst_pkg::K_LESS : tst_pkg::K_GREATER);
        return 1;
      end
      tst_pkg::PH_SLASH: begin
        if (c == "/") begin phase = tst_pkg::PH_LINE; return 0; end
        if (c == "*") begin phase = tst_pkg::PH_BLOCK; return 0; end
        emit_tok(tst_pkg::K_SLASH);
        return 1;
      end
      tst_pkg::PH_LINE: begin
        if (c == "\n" || c == 8'd0) begin
          if (!drop_cmt) emit_tok(tst_pkg::K_COMMENT);
          clear_scan();
          return c == 8'd0;
        end
        emit_text(c);
        return 0;
      end
      tst_pkg::PH_BLOCK, tst_pkg::PH_BLOCK_STAR: begin
        if (c == 8'd0) begin
          emit_err(tst_pkg::E_OPEN_BLOCK); clear_scan(); return 1;
        end
        if (phase == tst_pkg::PH_BLOCK_STAR) begin
          if (c == "/") begin
            if (!drop_cmt) emit_tok(tst_pkg::K_COMMENT);
            clear_scan(); return 0;
          end
          emit_text("*");
        end
        if (c == "*") begin phase = tst_pkg::PH_BLOCK_STAR; return 0; end
        phase = tst_pkg::PH_BLOCK;
        emit_text(c);
        return 0;
      end
      tst_pkg::PH_STRING: begin
        if (c == "\"") begin emit_tok(tst_pkg::K_STRING); clear_scan(); return 0; end
        if (c == "\n" || c == 8'd0) begin
          emit_err(tst_pkg::E_OPEN_STR); clear_scan(); return 1;
        end
        emit_text(c);
        return 0;
      end
      tst_pkg::PH_IDENT: begin
        if (alpha_c(c) || digit_c(c) || c == "_") begin
          if (idlen < tst_pkg::MAX_ID_LEN) idbuf[idlen] = c;
          if (idlen <= tst_pkg::MAX_ID_LEN) idlen++;
          return 0;
        end
        close_ident();
        return 1;
      end
      tst_pkg::PH_ZERO, tst_pkg::PH_INT: begin
        if (phase == tst_pkg::PH_ZERO && c == "0") begin
          emit_err(tst_pkg::E_LEAD_ZERO); return 1;
        end
        if (digit_c(c)) begin
          if (32'(accum) > lim) begin
            emit_err(tst_pkg::E_INT_OVF); clear_scan(); return 0;
          end
          accum = 31'(32'(accum) * 10 + d);
          phase = tst_pkg::PH_INT;
          return 0;
        end
        if (c == ".") begin fcount = '0; phase = tst_pkg::PH_FRAC; return 0; end
        emit(tst_pkg::K_INT, accum, '0, '0, tst_pkg::E_NONE, 1'b1);
        return 1;
      end
      tst_pkg::PH_FRAC: begin
        if (digit_c(c)) begin
          if (32'(accum) > lim || fcount >= tst_pkg::FRAC_MAX) begin
            emit_err(tst_pkg::E_DEC_RANGE); clear_scan(); return 0;
          end
          accum = 31'(32'(accum) * 10 + d);
          fcount++;
          return 0;
        end
        if (fcount == 0) emit_err(tst_pkg::E_NO_FRAC);
        else emit(tst_pkg::K_DECIMAL, accum, fcount, '0, tst_pkg::E_NONE, 1'b1);
        return 1;
      end
      default: return 1;
    endcase
  endfunction

  task automatic predict_byte(logic [7:0] c);
    if (phase == tst_pkg::PH_IDLE || continue_token(c)) start_token(c);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("source_text_tokenizer_unit regression: fail");
      $finish;
    end
  end

  // Driver: offer pending bytes, with a random gap after each
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !in_taken) begin
        // hold the item
      end else if (send_gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (bytes_pending.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= bytes_pending.pop_front();
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end else begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end
  end

  // Predict on each accepted byte
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) predict_byte(s_axis_tdata_i);
  end

  // Receiver readiness: random stalls, plus long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off <= 300;
      m_axis_tready_i <= 1'b0;
    end else if (hold_off > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (recv_gap > 0) begin
      m_axis_tready_i <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (m_axis_tvalid_o && $urandom_range(0, 2) == 0) recv_gap <= $urandom_range(0, 16);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    token_rec_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = m_axis_tuser_o;
      got.num  = m_axis_tdata_o[30:0];
      got.frac = m_axis_tdata_o[34:31];
      got.ch   = m_axis_tdata_o[42:35];
      got.err  = m_axis_tdata_o[46:43];
      got.last = m_axis_tlast_o;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", got.kind));
      end else begin
        want = tokens_due.pop_front();
        if (got.kind != want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.num != want.num)
          report_mismatch($sformatf("number %0d, want %0d", got.num, want.num));
        if (got.frac != want.frac)
          report_mismatch($sformatf("fraction %0d, want %0d", got.frac, want.frac));
        if (got.ch != want.ch)
          report_mismatch($sformatf("char %0d, want %0d", got.ch, want.ch));
        if (got.err != want.err)
          report_mismatch($sformatf("error %0d, want %0d", got.err, want.err));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
      end
    end
  end

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) bytes_pending.push_back(s[i]);
  endtask

  task automatic wait_drained();
    while (bytes_pending.size() > 0 || s_axis_tvalid_i || tokens_due.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_drop(logic v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    drop_cmt = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random fragment: mostly well-formed tokens, some noise
  task automatic queue_fragment();
    string frags[20] = '{"if ", "inspect(", "variant ", "default;", "abc_9 ", "x1=>y ",
                         "a!=b ", "c<=d>=e ", "== ", "\"str x\" ", "// note\n",
                         "/* a*b **/", "12.345 ", "2147483647 ", "0.5 ", "007 ",
                         "3. ", "{},.-+*", "while return ", "_long_identifier_name "};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      queue_text(frags[$urandom_range(0, 19)]);
    end else if (sel == 7) begin
      bytes_pending.push_back(8'($urandom_range(1, 255)));
    end else if (sel == 8) begin
      for (int i = 0; i < $urandom_range(1, 12); i++)
        bytes_pending.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) queue_text(".");
      for (int i = 0; i < $urandom_range(0, 12); i++)
        bytes_pending.push_back(8'("0" + $urandom_range(0, 9)));
      queue_text(" ");
    end else begin
      for (int i = 0; i < $urandom_range(1, 40); i++)
        bytes_pending.push_back(8'("a" + $urandom_range(0, 25)));
      queue_text(" ");
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    drop_cmt = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: operators, keywords, numbers, comments, strings, errors
    write_drop(1'b0);
    queue_text("(){},.-+;*! != = == => < <= > >= / if else");
    queue_text(" x 2147483648 00 01 1.5 1. 1.12345678901 @\x80\xff");
    queue_text("// hi\n/* a*b */\"ab\n\"q\"");
    bytes_pending.push_back(8'd0);
    wait_drained();

    // Long receiver hold-off while bytes keep coming
    hold_req = 1'b1;
    queue_text("abcdefghijklmnopqrstuvwxyzabcdefgh /* xx");
    bytes_pending.push_back(8'd0);
    wait_drained();

    // Drop comments, including open block at end
    write_drop(1'b1);
    queue_text("// gone\n/* a** b */ x /* open");
    bytes_pending.push_back(8'd0);
    queue_text("// tail");
    bytes_pending.push_back(8'd0);
    wait_drained();

    // Random phases at both settings
    for (int ph = 0; ph < 2; ph++) begin
      write_drop(1'(ph & 1));
      for (int n = 0; n < 2; n++) queue_fragment();
      bytes_pending.push_back(8'd0);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("source_text_tokenizer_unit regression: pass");
    end else begin
      $display("source_text_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tst_pkg.sv
sv/tst_front.sv
sv/tst_back.sv
sv/source_text_tokenizer_unit.sv
test/tb_source_text_tokenizer_unit.sv
